@@ rtl/srr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pkg
// shared types and codes for the selective-repeat receiver
// ----------------------------------------------------------------------------
package srr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DELIVER
  } srr_state_t;

  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_DROP    = 2'd2;
  localparam logic [1:0] KIND_DUP     = 2'd3;

  typedef struct packed {
    logic shift;
    logic load;
  } srr_cell_ctrl_t;

endpackage

@@ rtl/selective_repeat_receiver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit
// selective-repeat receive window built as a row of cells, cell 0 at the base
// ----------------------------------------------------------------------------
//  channel  handshake            fields
//  in       in_valid/in_stall    seq_num, is_last, payload
//  out      out_valid/out_stall  kind, ack_seq, out_payload, finished, last_of_run
//
//  a packet is captured in idle and judged in eval; one that lands on the base
//  then passes through deliver, which hands out the in-order words one by one,
//  the cell row shifting one position per delivery
//  result words leave through a single output register; a stalled output
//  holds the sequencer, and in_stall is high while a packet is in hand
//  synchronous reset empties the window and clears the base and finished flag
// ----------------------------------------------------------------------------
module selective_repeat_receiver_unit import srr_pkg::*; #(
  parameter int WINDOW       = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [$clog2(2*WINDOW)-1:0]       seq_num,
  input  logic                              is_last,
  input  logic [PAYLOAD_BITS-1:0]           payload,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        kind,
  output logic [$clog2(2*WINDOW)-1:0]       ack_seq,
  output logic [PAYLOAD_BITS-1:0]           out_payload,
  output logic                              finished,
  output logic                              last_of_run
);

  localparam int SEQ_SPAN = 2 * WINDOW;
  localparam int SEQ_BITS = $clog2(SEQ_SPAN);
  localparam int IDX_BITS = $clog2(WINDOW);
  localparam logic [SEQ_BITS:0]   SPAN_W = (SEQ_BITS+1)'(SEQ_SPAN);
  localparam logic [SEQ_BITS:0]   WIN_W  = (SEQ_BITS+1)'(WINDOW);
  localparam logic [SEQ_BITS-1:0] SEQ_MAX = SEQ_BITS'(SEQ_SPAN - 1);

  srr_state_t state, state_next;

  logic [SEQ_BITS-1:0]     cur_seq;
  logic                    cur_last;
  logic [PAYLOAD_BITS-1:0] cur_word;
  logic [SEQ_BITS-1:0]     base;
  logic                    last_seen;
  logic [IDX_BITS-1:0]     last_slot;
  logic                    done_flag;

  logic [WINDOW-1:0]       cell_filled;
  logic [PAYLOAD_BITS-1:0] cell_word [WINDOW];

  logic [SEQ_BITS:0]   seq_in_w, diff_a, diff_b, ahead_w, behind_w, base_w, cur_w;
  logic [SEQ_BITS-1:0] seq_red;
  logic [IDX_BITS-1:0] ahead_idx, base_slot, seq_slot;
  logic                in_win, prev_win, out_free;

  logic                    emit, emit_last, wr, shift, done_next;
  logic [1:0]              emit_kind;
  logic [SEQ_BITS-1:0]     emit_seq;
  logic [PAYLOAD_BITS-1:0] emit_word;

  // sequence reduced into the span on the way in
  assign seq_in_w = {1'b0, seq_num};
  assign seq_red  = (seq_in_w >= SPAN_W) ? SEQ_BITS'(seq_in_w - SPAN_W) : seq_num;

  assign base_w   = {1'b0, base};
  assign cur_w    = {1'b0, cur_seq};
  assign diff_a   = cur_w + SPAN_W - base_w;
  assign diff_b   = base_w + SPAN_W - cur_w;
  assign ahead_w  = (diff_a >= SPAN_W) ? diff_a - SPAN_W : diff_a;
  assign behind_w = (diff_b >= SPAN_W) ? diff_b - SPAN_W : diff_b;
  assign in_win   = ahead_w < WIN_W;
  assign prev_win = (behind_w != '0) && (behind_w <= WIN_W);
  assign ahead_idx = IDX_BITS'(ahead_w);
  assign base_slot = (base_w >= WIN_W) ? IDX_BITS'(base_w - WIN_W) : IDX_BITS'(base_w);
  assign seq_slot  = (cur_w >= WIN_W) ? IDX_BITS'(cur_w - WIN_W) : IDX_BITS'(cur_w);

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // cell row
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    srr_cell_ctrl_t          ctrl;
    logic                    nbr_filled;
    logic [PAYLOAD_BITS-1:0] nbr_word;

    assign ctrl.shift = shift;
    assign ctrl.load  = wr && (ahead_idx == IDX_BITS'(i));

    if (i == WINDOW - 1) begin : g_end
      assign nbr_filled = 1'b0;
      assign nbr_word   = '0;
    end else begin : g_mid
      assign nbr_filled = cell_filled[i+1];
      assign nbr_word   = cell_word[i+1];
    end

    srr_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .load_word (cur_word),
      .nbr_filled(nbr_filled),
      .nbr_word  (nbr_word),
      .filled    (cell_filled[i]),
      .word      (cell_word[i])
    );
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_kind  = KIND_ACK;
    emit_seq   = cur_seq;
    emit_word  = '0;
    wr         = 1'b0;
    shift      = 1'b0;
    done_next  = done_flag;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          if (in_win) begin
            if (cell_filled[ahead_idx]) begin
              emit       = 1'b1;
              emit_last  = 1'b1;
              emit_kind  = KIND_DUP;
              state_next = ST_IDLE;
            end else begin
              wr = 1'b1;
              if (ahead_w == '0) begin
                state_next = ST_DELIVER;
              end else begin
                emit       = 1'b1;
                emit_last  = 1'b1;
                emit_kind  = KIND_ACK;
                state_next = ST_IDLE;
              end
            end
          end else begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            emit_kind  = prev_win ? KIND_ACK : KIND_DROP;
            state_next = ST_IDLE;
          end
        end
      end
      ST_DELIVER: begin
        if (out_free) begin
          emit = 1'b1;
          if (cell_filled[0]) begin
            emit_kind = KIND_DELIVER;
            emit_seq  = base;
            emit_word = cell_word[0];
            shift     = 1'b1;
            if (last_seen && (last_slot == base_slot)) begin
              done_next = 1'b1;
            end
          end else begin
            emit_kind  = KIND_ACK;
            emit_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cur_seq  <= seq_red;
      cur_last <= is_last;
      cur_word <= payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      last_seen <= 1'b0;
      last_slot <= '0;
      done_flag <= 1'b0;
    end else begin
      done_flag <= done_next;
      if (wr && cur_last) begin
        last_seen <= 1'b1;
        last_slot <= seq_slot;
      end
      if (shift) begin
        base <= (base == SEQ_MAX) ? '0 : base + 1'b1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind        <= emit_kind;
      ack_seq     <= emit_seq;
      out_payload <= emit_word;
      finished    <= done_next;
      last_of_run <= emit_last;
    end
  end

endmodule

@@ rtl/srr_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_cell
// one window position: filled flag and buffered word, shifts towards the base
// ----------------------------------------------------------------------------
module srr_cell import srr_pkg::*; #(
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  srr_cell_ctrl_t          ctrl,
  input  logic [PAYLOAD_BITS-1:0] load_word,
  input  logic                    nbr_filled,
  input  logic [PAYLOAD_BITS-1:0] nbr_word,
  output logic                    filled,
  output logic [PAYLOAD_BITS-1:0] word
);

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= 1'b0;
    end else if (ctrl.shift) begin
      filled <= nbr_filled;
    end else if (ctrl.load) begin
      filled <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      word <= nbr_word;
    end else if (ctrl.load) begin
      word <= load_word;
    end
  end

endmodule

@@ tb/sv/srr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_checker
// watches both channels of the selective-repeat receiver, keeps its own copy
// of the receive window, works out the result words each accepted packet
// must cause and compares every result word field by field, in order
// ----------------------------------------------------------------------------
module srr_checker import srr_pkg::*; #(
  parameter int WINDOW       = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [$clog2(2*WINDOW)-1:0]       seq_num,
  input  logic                              is_last,
  input  logic [PAYLOAD_BITS-1:0]           payload,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [1:0]                        kind,
  input  logic [$clog2(2*WINDOW)-1:0]       ack_seq,
  input  logic [PAYLOAD_BITS-1:0]           out_payload,
  input  logic                              finished,
  input  logic                              last_of_run,
  input  logic                              end_of_run,
  output int                                fail_count,
  output int                                pending
);

  localparam int SEQ_W = $clog2(2*WINDOW);
  localparam int SPAN  = 2*WINDOW;

  typedef struct packed {
    logic [1:0]              kind;
    logic [SEQ_W-1:0]        seq;
    logic [PAYLOAD_BITS-1:0] data;
    logic                    fin;
    logic                    last;
  } srr_word_t;

  srr_word_t               expected_words[$];

  int unsigned             base_seq;
  logic                    slot_full [WINDOW];
  logic [PAYLOAD_BITS-1:0] slot_word [WINDOW];
  logic                    last_flagged;
  int unsigned             last_flag_slot;
  logic                    done_seen;

  int n_packets, n_words, n_deliver, n_ack, n_dup, longest_run;
  logic leftover_checked;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    fail_count++;
    if (fail_count <= 30)
      $display("mismatch: %s got %0h expected %0h", what, got, want);
  endtask

  task automatic add_word(input logic [1:0] k, input int unsigned s,
                          input logic [PAYLOAD_BITS-1:0] d);
    srr_word_t w;
    w.kind = k;
    w.seq  = s[SEQ_W-1:0];
    w.data = d;
    w.fin  = done_seen;
    w.last = 1'b0;
    expected_words.push_back(w);
  endtask

  // works out the result words for one accepted packet and updates the window
  task automatic predict_packet(input logic [SEQ_W-1:0] seq_in, input logic last_in,
                                input logic [PAYLOAD_BITS-1:0] data_in);
    int unsigned seq, ahead, behind, slot, s, run;
    logic        more;
    srr_word_t   w;
    seq    = 32'(seq_in);
    ahead  = (seq + SPAN - base_seq) % SPAN;
    behind = (base_seq + SPAN - seq) % SPAN;
    if (ahead < WINDOW) begin
      slot = seq % WINDOW;
      if (slot_full[slot]) begin
        add_word(KIND_DUP, seq, '0);
      end else begin
        if (last_in) begin
          last_flagged   = 1'b1;
          last_flag_slot = slot;
        end
        slot_full[slot] = 1'b1;
        slot_word[slot] = data_in;
        if (seq == base_seq) begin
          run  = 0;
          more = 1'b1;
          while (more && run < WINDOW) begin
            s = (slot + run) % WINDOW;
            if (!slot_full[s]) begin
              more = 1'b0;
            end else begin
              slot_full[s] = 1'b0;
              if (last_flagged && last_flag_slot == s) done_seen = 1'b1;
              add_word(KIND_DELIVER, base_seq, slot_word[s]);
              base_seq = (base_seq + 1) % SPAN;
              run++;
            end
          end
          if (run > longest_run) longest_run = run;
        end
        add_word(KIND_ACK, seq, '0);
      end
    end else if (behind >= 1 && behind <= WINDOW) begin
      add_word(KIND_ACK, seq, '0);
    end else begin
      add_word(KIND_DROP, seq, '0);
    end
    w = expected_words.pop_back();
    w.last = 1'b1;
    expected_words.push_back(w);
  endtask

  task automatic check_word();
    srr_word_t w;
    if (expected_words.size() == 0) begin
      report_mismatch("result word with nothing expected, kind", 64'(kind), 64'd0);
    end else begin
      w = expected_words.pop_front();
      if (kind !== w.kind)
        report_mismatch("kind", 64'(kind), 64'(w.kind));
      if (ack_seq !== w.seq)
        report_mismatch("ack_seq", 64'(ack_seq), 64'(w.seq));
      if (out_payload !== w.data)
        report_mismatch("out_payload", 64'(out_payload), 64'(w.data));
      if (finished !== w.fin)
        report_mismatch("finished", 64'(finished), 64'(w.fin));
      if (last_of_run !== w.last)
        report_mismatch("last_of_run", 64'(last_of_run), 64'(w.last));
    end
    n_words++;
    case (kind)
      KIND_DELIVER: n_deliver++;
      KIND_ACK:     n_ack++;
      KIND_DUP:     n_dup++;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      base_seq       = 0;
      for (int i = 0; i < WINDOW; i++) slot_full[i] = 1'b0;
      last_flagged   = 1'b0;
      last_flag_slot = 0;
      done_seen      = 1'b0;
      fail_count     = 0;
      n_packets      = 0;
      n_words        = 0;
      n_deliver      = 0;
      n_ack          = 0;
      n_dup          = 0;
      longest_run    = 0;
      leftover_checked = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_packet(seq_num, is_last, payload);
        n_packets++;
      end
      if (out_valid && !out_stall) check_word();
      if (end_of_run && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_words.size() != 0)
          report_mismatch("result words never delivered, count", 64'd0,
                          64'(expected_words.size()));
        $display("checked %0d packets against %0d result words: ", n_packets, n_words,
                 "%0d delivered, %0d acks, %0d duplicates", n_deliver, n_ack, n_dup);
        $display("longest in-order run %0d words, finished flag %0b at the end",
                 longest_run, done_seen);
      end
    end
    pending = expected_words.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the selective-repeat receiver: a directed opening through the
// duplicate, previous-window, long in-order run and finish cases, then whole
// windows sent in order, reversed or shuffled with repeats and early packets
// mixed in, under random idling on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module tb;
  import srr_pkg::*;

  localparam int WINDOW       = 8;
  localparam int PAYLOAD_BITS = 32;
  localparam int SEQ_W        = $clog2(2*WINDOW);
  localparam int N_DIRECTED   = 15;
  localparam int N_RANDOM     = 235;
  localparam int CYCLE_LIMIT  = 200000;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [SEQ_W-1:0]        seq_num;
  logic                    is_last;
  logic [PAYLOAD_BITS-1:0] payload;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              kind;
  logic [SEQ_W-1:0]        ack_seq;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    finished;
  logic                    last_of_run;
  logic                    end_of_run;
  int                      fail_count;
  int                      pending;

  int   packets_sent = 0;
  int   cycle_count  = 0;
  logic calm         = 1'b0;
  logic hold_done    = 1'b0;

  selective_repeat_receiver_unit #(
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .seq_num     (seq_num),
    .is_last     (is_last),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .ack_seq     (ack_seq),
    .out_payload (out_payload),
    .finished    (finished),
    .last_of_run (last_of_run)
  );

  srr_checker #(
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .seq_num     (seq_num),
    .is_last     (is_last),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .ack_seq     (ack_seq),
    .out_payload (out_payload),
    .finished    (finished),
    .last_of_run (last_of_run),
    .end_of_run  (end_of_run),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // offers one packet word and holds it until taken
  task automatic send_pkt(input logic [SEQ_W-1:0] s, input logic l,
                          input logic [PAYLOAD_BITS-1:0] d);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    seq_num  <= s;
    is_last  <= l;
    payload  <= d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    packets_sent++;
  endtask

  // one whole window from start, with repeats and early packets mixed in
  task automatic send_window(input logic [SEQ_W-1:0] start);
    logic [SEQ_W-1:0] order [WINDOW];
    logic [SEQ_W-1:0] tmp;
    logic [SEQ_W-1:0] s;
    int               mode, j;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < WINDOW; i++)
      order[i] = (mode == 1) ? start + SEQ_W'(WINDOW - 1 - i) : start + SEQ_W'(i);
    if (mode >= 2) begin
      for (int i = WINDOW - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    for (int k = 0; k < WINDOW; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        if (k > 0 && $urandom_range(0, 1) == 1)
          s = order[$urandom_range(0, k - 1)];
        else
          s = start + SEQ_W'(WINDOW + $urandom_range(0, WINDOW - 1));
        send_pkt(s, 1'($urandom_range(0, 1)), $urandom);
      end
      send_pkt(order[k], $urandom_range(0, 19) == 0, $urandom);
    end
  endtask

  // receiver side: random stall bursts, one long hold-off, calm at the end
  initial begin
    out_stall = 1'b0;
    forever begin
      if (!hold_done && packets_sent >= 40) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
      end else if (calm || rst) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else begin
        out_stall <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
    end
  end

  initial begin
    logic [SEQ_W-1:0] tx_base;
    rst        = 1'b1;
    in_valid   = 1'b0;
    seq_num    = '0;
    is_last    = 1'b0;
    payload    = '0;
    end_of_run = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // base word, a gap, a repeat of the gap word and two previous-window words
    send_pkt(4'd0, 1'b0, 32'h0000_0000);
    send_pkt(4'd2, 1'b0, 32'hFFFF_FFFF);
    send_pkt(4'd2, 1'b1, 32'h1234_5678);
    send_pkt(4'd9, 1'b0, 32'hDEAD_BEEF);
    send_pkt(4'd15, 1'b1, 32'hAAAA_AAAA);
    send_pkt(4'd1, 1'b0, 32'hA5A5_A5A5);
    // fill the rest of the window out of order, last flag on the top word,
    // then the base word releases the longest run
    send_pkt(4'd4, 1'b0, 32'h5555_5555);
    send_pkt(4'd5, 1'b0, 32'h8000_0001);
    send_pkt(4'd6, 1'b0, 32'h7FFF_FFFE);
    send_pkt(4'd7, 1'b0, 32'h0F0F_0F0F);
    send_pkt(4'd8, 1'b0, 32'hF0F0_F0F0);
    send_pkt(4'd9, 1'b0, 32'h0000_0001);
    send_pkt(4'd10, 1'b1, 32'hC3C3_C3C3);
    send_pkt(4'd3, 1'b0, 32'h3C3C_3C3C);
    // traffic after finish
    send_pkt(4'd11, 1'b1, 32'h5A5A_5A5A);

    tx_base = 4'd12;
    while (packets_sent < N_DIRECTED + N_RANDOM) begin
      if (packets_sent >= N_DIRECTED + N_RANDOM - 50) calm = 1'b1;
      send_window(tx_base);
      tx_base = tx_base + SEQ_W'(WINDOW);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
